// File: rtl/rrnh_pkg.sv
// Shared types, widths and helpers for the ray / rectangle nearest-hit block.
// Used by rrnh_mac, rrnh_divsqrt and ray_rectangle_nearest_hit.
`default_nettype none
package rrnh_pkg;

  localparam int ACC_W  = 72;   // holds every exact cross product
  localparam int OP_W   = 36;   // signed multiplier operand
  localparam int HALF_W = 18;   // operand chunk per multiply cycle
  localparam int FRAC   = 16;
  localparam logic [16:0] PONE = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ, ST_SQRT, ST_MUL_X, ST_DIV_X, ST_MUL_Y, ST_DIV_Y,
    ST_SETUP, ST_DEN, ST_FIX, ST_NT, ST_NU, ST_CHK, ST_DIV_T, ST_NEXT,
    ST_FINISH, ST_HIT_X, ST_HIT_Y, ST_EMIT
  } state_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
    logic hi;
  } mac_cmd_t;

  typedef struct packed {
    logic       start;
    logic       sqrt_mode;
    logic [5:0] steps;
  } div_cmd_t;

  // Clamp a 35-bit signed sum to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic [34:0] s);
    logic [31:0] r;
    if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) begin
      r = s[31:0];
    end else if (s[34]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ray_rectangle_nearest_hit.sv
// Top level of the ray / rectangle nearest-hit block: sequencer and state.
// Depends on rrnh_pkg, rrnh_mac and rrnh_divsqrt.
`default_nettype none
// A start request (tuser 0) sets the ray origin and turns direction and
// distance into a ray vector of that length; each rectangle request (tuser 1)
// is tested edge by edge against that ray unless its entity is the excluded
// one, and the request marked tlast produces one result: hit flag in tuser,
// entity and hit point in tdata (zero when nothing was hit). All values are
// Q16.16. One request is worked at a time and tready is low meanwhile; every
// product runs through one 36x18 multiply-accumulate unit (two partial
// products per product, four per cross product) and every quotient and the
// square root through one bit-serial divide/root unit. A start request
// squares the direction, takes its root, then multiplies and divides each
// component in turn; a zero direction stops after the root. A rectangle edge
// stops when parallel to the ray or when the cross products reject it, else
// it goes on to the division; an excluded rectangle skips its edges. A tlast
// request then forms the hit point on a hit and loads the result register,
// waiting while an earlier result is still held. The result sits in an
// output register, so the next request is accepted while it waits to be
// taken.
module ray_rectangle_nearest_hit (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // coord_x, coord_y, extent_x, extent_y, ray_length, entity_id, zero pad
  input  wire  [175:0] s_axis_tdata,
  // action
  input  wire          s_axis_tuser,
  input  wire          s_axis_tlast,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // hit_entity, hit_x, hit_y
  output logic [79:0]  m_axis_tdata,
  // hit_found
  output logic         m_axis_tuser
);

  localparam int AW = rrnh_pkg::ACC_W;
  localparam int OW = rrnh_pkg::OP_W;

  rrnh_pkg::state_t state, state_next;
  logic [1:0] cnt;
  logic       div_go;

  // request fields
  logic [31:0] in_cx, in_cy, in_ex, in_ey;
  logic [30:0] in_dist;
  logic [15:0] in_ent;
  logic        s_acc;

  // latched request
  logic [31:0] ex, ey, abs_x, abs_y;
  logic [30:0] ray_dist;
  logic [15:0] ent;
  logic        last;
  logic [32:0] rx, ry, xw, yh, rw, rh, nw, nh;

  // ray and search state
  logic [31:0] ox, oy, vx, vy;
  logic [15:0] excl, best_ent;
  logic [16:0] best;
  logic [31:0] ray_len;

  // edge state
  logic [1:0]  k;
  logic [33:0] ax, ay;
  logic [32:0] sx, sy;
  logic [AW-1:0] den, nt;
  logic        flip;
  logic [31:0] hx;

  // output register
  logic        o_valid, o_hit;
  logic [15:0] o_ent;
  logic [31:0] o_x, o_y;

  // shared units
  rrnh_pkg::mac_cmd_t mcmd;
  rrnh_pkg::div_cmd_t dcmd;
  logic [OW-1:0] mul_a, mul_b;
  logic [AW-1:0] acc;
  logic [AW-1:0] d_rem, d_dsr;
  logic [63:0]   d_src;
  logic          d_busy;
  logic [31:0]   d_q;
  logic          div_fin;

  logic          chk_pass;
  logic          hit;
  logic          emit_adv;
  logic [31:0]   hy;
  logic [32:0]   px, py;
  logic [31:0]   q_signed_x, q_signed_y;

  assign in_cx   = s_axis_tdata[31:0];
  assign in_cy   = s_axis_tdata[63:32];
  assign in_ex   = s_axis_tdata[95:64];
  assign in_ey   = s_axis_tdata[127:96];
  assign in_dist = s_axis_tdata[158:128];
  assign in_ent  = s_axis_tdata[174:159];

  assign s_axis_tready = (state == rrnh_pkg::ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign div_fin       = ~div_go & ~d_busy;
  assign hit           = (best < rrnh_pkg::PONE);
  assign emit_adv      = (state == rrnh_pkg::ST_EMIT) & (~o_valid | m_axis_tready);

  assign chk_pass = ~nt[AW-1] & ~acc[AW-1] & (nt <= den) & (acc <= den);

  // hit point: origin plus floor(vec * param / 2^16), clamped
  assign hy = rrnh_pkg::sat32({{3{oy[31]}}, oy} + {acc[49], acc[49:16]});
  assign q_signed_x = ex[31] ? (~d_q + 32'd1) : d_q;
  assign q_signed_y = ey[31] ? (~d_q + 32'd1) : d_q;

  // corner of the current edge, walked from (x, y) through (x, y+h), (x+w, y+h) and (x+w, y)
  always_comb begin
    case (k)
      2'd0:    begin px = rx; py = ry; end
      2'd1:    begin px = rx; py = yh; end
      2'd2:    begin px = xw; py = yh; end
      default: begin px = xw; py = ry; end
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rrnh_pkg::ST_IDLE;
      cnt    <= '0;
      div_go <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= (state_next != state) ? 2'd0 : cnt + 2'd1;
      div_go <= (state_next != state) &&
                (state_next inside {rrnh_pkg::ST_SQRT, rrnh_pkg::ST_DIV_X,
                                    rrnh_pkg::ST_DIV_Y, rrnh_pkg::ST_DIV_T});
    end
  end

  always_comb begin
    state_next = state;
    mcmd       = '0;
    mcmd.hi    = cnt[0];
    mcmd.clr   = (cnt == 2'd0);
    mul_a      = '0;
    mul_b      = '0;
    dcmd       = '0;
    dcmd.start = div_go;
    d_rem      = '0;
    d_src      = '0;
    d_dsr      = '0;
    case (state)
      rrnh_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (!s_axis_tuser) begin
            state_next = rrnh_pkg::ST_SQ;
          end else if (in_ent == excl) begin
            state_next = rrnh_pkg::ST_FINISH;
          end else begin
            state_next = rrnh_pkg::ST_SETUP;
          end
        end
      end
      rrnh_pkg::ST_SQ: begin
        mcmd.en = 1'b1;
        mul_a   = cnt[1] ? {{4{ey[31]}}, ey} : {{4{ex[31]}}, ex};
        mul_b   = mul_a;
        if (cnt == 2'd3) state_next = rrnh_pkg::ST_SQRT;
      end
      rrnh_pkg::ST_SQRT: begin
        dcmd.sqrt_mode = 1'b1;
        dcmd.steps     = 6'd32;
        d_src          = acc[63:0];
        if (div_fin) begin
          state_next = (d_q == 32'd0) ? rrnh_pkg::ST_FINISH : rrnh_pkg::ST_MUL_X;
        end
      end
      rrnh_pkg::ST_MUL_X, rrnh_pkg::ST_MUL_Y: begin
        mcmd.en = 1'b1;
        mul_a   = {4'd0, (state == rrnh_pkg::ST_MUL_X) ? abs_x : abs_y};
        mul_b   = {5'd0, ray_dist};
        if (cnt == 2'd1) begin
          state_next = (state == rrnh_pkg::ST_MUL_X) ? rrnh_pkg::ST_DIV_X
                                                     : rrnh_pkg::ST_DIV_Y;
        end
      end
      rrnh_pkg::ST_DIV_X, rrnh_pkg::ST_DIV_Y: begin
        dcmd.steps = 6'd31;
        d_rem      = {31'd0, acc[AW-1:31]};
        d_src      = {acc[30:0], 33'd0};
        d_dsr      = {40'd0, ray_len};
        if (div_fin) begin
          state_next = (state == rrnh_pkg::ST_DIV_X) ? rrnh_pkg::ST_MUL_Y
                                                     : rrnh_pkg::ST_FINISH;
        end
      end
      rrnh_pkg::ST_SETUP: begin
        state_next = rrnh_pkg::ST_DEN;
      end
      rrnh_pkg::ST_DEN: begin
        // den = vec x edge
        mcmd.en  = 1'b1;
        mcmd.neg = cnt[1];
        mul_a    = cnt[1] ? {{4{vy[31]}}, vy} : {{4{vx[31]}}, vx};
        mul_b    = cnt[1] ? {{3{sx[32]}}, sx} : {{3{sy[32]}}, sy};
        if (cnt == 2'd3) state_next = rrnh_pkg::ST_FIX;
      end
      rrnh_pkg::ST_FIX: begin
        // drop parallel edges
        state_next = (acc == '0) ? rrnh_pkg::ST_NEXT : rrnh_pkg::ST_NT;
      end
      rrnh_pkg::ST_NT: begin
        mcmd.en  = 1'b1;
        mcmd.neg = cnt[1] ^ flip;
        mul_a    = cnt[1] ? {{2{ay[33]}}, ay} : {{2{ax[33]}}, ax};
        mul_b    = cnt[1] ? {{3{sx[32]}}, sx} : {{3{sy[32]}}, sy};
        if (cnt == 2'd3) state_next = rrnh_pkg::ST_NU;
      end
      rrnh_pkg::ST_NU: begin
        mcmd.en  = 1'b1;
        mcmd.neg = cnt[1] ^ flip;
        mul_a    = cnt[1] ? {{2{ay[33]}}, ay} : {{2{ax[33]}}, ax};
        mul_b    = cnt[1] ? {{4{vx[31]}}, vx} : {{4{vy[31]}}, vy};
        if (cnt == 2'd3) state_next = rrnh_pkg::ST_CHK;
      end
      rrnh_pkg::ST_CHK: begin
        state_next = chk_pass ? rrnh_pkg::ST_DIV_T : rrnh_pkg::ST_NEXT;
      end
      rrnh_pkg::ST_DIV_T: begin
        // quotient of (nt << 16) / den never exceeds one, so 17 bits suffice
        dcmd.steps = 6'd17;
        d_rem      = {1'b0, nt[AW-1:1]};
        d_src      = {nt[0], 63'd0};
        d_dsr      = den;
        if (div_fin) state_next = rrnh_pkg::ST_NEXT;
      end
      rrnh_pkg::ST_NEXT: begin
        state_next = (k == 2'd3) ? rrnh_pkg::ST_FINISH : rrnh_pkg::ST_SETUP;
      end
      rrnh_pkg::ST_FINISH: begin
        if (!last) begin
          state_next = rrnh_pkg::ST_IDLE;
        end else if (hit) begin
          state_next = rrnh_pkg::ST_HIT_X;
        end else begin
          state_next = rrnh_pkg::ST_EMIT;
        end
      end
      rrnh_pkg::ST_HIT_X, rrnh_pkg::ST_HIT_Y: begin
        mcmd.en = 1'b1;
        mul_a   = (state == rrnh_pkg::ST_HIT_X) ? {{4{vx[31]}}, vx} : {{4{vy[31]}}, vy};
        mul_b   = {19'd0, best};
        if (cnt == 2'd1) begin
          state_next = (state == rrnh_pkg::ST_HIT_X) ? rrnh_pkg::ST_HIT_Y
                                                     : rrnh_pkg::ST_EMIT;
        end
      end
      rrnh_pkg::ST_EMIT: begin
        if (emit_adv) state_next = rrnh_pkg::ST_IDLE;
      end
      default: begin
        state_next = rrnh_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      ox       <= '0;
      oy       <= '0;
      vx       <= '0;
      vy       <= '0;
      excl     <= '0;
      best     <= rrnh_pkg::PONE;
      best_ent <= '0;
    end else begin
      case (state)
        rrnh_pkg::ST_IDLE: begin
          if (s_acc && !s_axis_tuser) begin
            // new ray: restart the search
            ox       <= in_cx;
            oy       <= in_cy;
            excl     <= in_ent;
            best     <= rrnh_pkg::PONE;
            best_ent <= '0;
          end
        end
        rrnh_pkg::ST_SQRT: begin
          if (div_fin && d_q == 32'd0) begin
            vx <= '0;
            vy <= '0;
          end
        end
        rrnh_pkg::ST_DIV_X: begin
          if (div_fin) vx <= q_signed_x;
        end
        rrnh_pkg::ST_DIV_Y: begin
          if (div_fin) vy <= q_signed_y;
        end
        rrnh_pkg::ST_DIV_T: begin
          // strict compare keeps the first of equal parameters
          if (div_fin && d_q[16:0] < best) begin
            best     <= d_q[16:0];
            best_ent <= ent;
          end
        end
        rrnh_pkg::ST_EMIT: begin
          if (emit_adv) begin
            best     <= rrnh_pkg::PONE;
            best_ent <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_acc) begin
      ex       <= in_ex;
      ey       <= in_ey;
      abs_x    <= in_ex[31] ? (~in_ex + 32'd1) : in_ex;
      abs_y    <= in_ey[31] ? (~in_ey + 32'd1) : in_ey;
      ray_dist <= in_dist;
      ent      <= in_ent;
      last     <= s_axis_tlast;
      rx       <= {in_cx[31], in_cx};
      ry       <= {in_cy[31], in_cy};
      rw       <= {in_ex[31], in_ex};
      rh       <= {in_ey[31], in_ey};
      xw       <= {in_cx[31], in_cx} + {in_ex[31], in_ex};
      yh       <= {in_cy[31], in_cy} + {in_ey[31], in_ey};
      nw       <= ~{in_ex[31], in_ex} + 33'd1;
      nh       <= ~{in_ey[31], in_ey} + 33'd1;
      k        <= 2'd0;
    end
    // hold the direction length as divisor for both components
    if (state == rrnh_pkg::ST_SQRT && div_fin) begin
      ray_len <= d_q;
    end
    if (state == rrnh_pkg::ST_SETUP) begin
      ax <= {px[32], px} - {{2{ox[31]}}, ox};
      ay <= {py[32], py} - {{2{oy[31]}}, oy};
      case (k)
        2'd0:    begin sx <= '0; sy <= rh; end
        2'd1:    begin sx <= rw; sy <= '0; end
        2'd2:    begin sx <= '0; sy <= nh; end
        default: begin sx <= nw; sy <= '0; end
      endcase
    end
    if (state == rrnh_pkg::ST_FIX) begin
      // fold the sign of den into the later cross products
      den  <= acc[AW-1] ? (~acc + {{(AW-1){1'b0}}, 1'b1}) : acc;
      flip <= acc[AW-1];
    end
    if (state == rrnh_pkg::ST_NU && cnt == 2'd0) begin
      nt <= acc;
    end
    if (state == rrnh_pkg::ST_NEXT) begin
      k <= k + 2'd1;
    end
    if (state == rrnh_pkg::ST_HIT_Y && cnt == 2'd0) begin
      hx <= rrnh_pkg::sat32({{3{ox[31]}}, ox} + {acc[49], acc[49:16]});
    end
    if (emit_adv) begin
      o_hit <= hit;
      o_ent <= hit ? best_ent : 16'd0;
      o_x   <= hit ? hx : 32'd0;
      o_y   <= hit ? hy : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit_adv) begin
      o_valid <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tuser  = o_hit;
  assign m_axis_tdata  = {o_y, o_x, o_ent};

  rrnh_mac u_mac (
    .clk  (clk),
    .cmd  (mcmd),
    .op_a (mul_a),
    .op_b (mul_b),
    .acc  (acc)
  );

  rrnh_divsqrt u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dcmd),
    .rem_init (d_rem),
    .src_init (d_src),
    .divisor  (d_dsr),
    .busy     (d_busy),
    .quot     (d_q)
  );

  // ---------------------------------------------------------------- checks
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    best <= rrnh_pkg::PONE)
    else $error("kept parameter above one");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    d_busy |-> (state == rrnh_pkg::ST_SQRT || state == rrnh_pkg::ST_DIV_X ||
                state == rrnh_pkg::ST_DIV_Y || state == rrnh_pkg::ST_DIV_T))
    else $error("divider running outside a divide state");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit_adv |=> m_axis_tvalid)
    else $error("result lost after emit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 80'd0))
    else $error("miss result carries data");

endmodule
`default_nettype wire

// File: rtl/rrnh_mac.sv
// Shared multiply-accumulate unit: 36 x 18 bit partial product per enabled cycle.
// Depends on rrnh_pkg for widths and the command struct.
`default_nettype none
module rrnh_mac (
  input  wire                        clk,
  input  wire rrnh_pkg::mac_cmd_t    cmd,
  input  wire [rrnh_pkg::OP_W-1:0]   op_a,
  input  wire [rrnh_pkg::OP_W-1:0]   op_b,
  output logic [rrnh_pkg::ACC_W-1:0] acc
);

  logic signed [rrnh_pkg::OP_W-1:0]     a_s;
  logic signed [rrnh_pkg::HALF_W:0]     chunk;
  logic signed [rrnh_pkg::OP_W+rrnh_pkg::HALF_W:0] prod;
  logic [rrnh_pkg::ACC_W-1:0] ext;
  logic [rrnh_pkg::ACC_W-1:0] shifted;
  logic [rrnh_pkg::ACC_W-1:0] addend;
  logic [rrnh_pkg::ACC_W-1:0] base;

  always_comb begin
    a_s   = op_a;
    // upper chunk is signed, lower chunk is a plain magnitude
    chunk = cmd.hi ? {op_b[rrnh_pkg::OP_W-1], op_b[rrnh_pkg::OP_W-1:rrnh_pkg::HALF_W]}
                   : {1'b0, op_b[rrnh_pkg::HALF_W-1:0]};
    prod  = a_s * chunk;
    ext   = {{(rrnh_pkg::ACC_W-rrnh_pkg::OP_W-rrnh_pkg::HALF_W-1){prod[$high(prod)]}}, prod};
    shifted = cmd.hi ? (ext << rrnh_pkg::HALF_W) : ext;
    addend  = cmd.neg ? ~shifted : shifted;
    base    = cmd.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      acc <= base + addend + {{(rrnh_pkg::ACC_W-1){1'b0}}, cmd.neg};
    end
  end

endmodule
`default_nettype wire

// File: rtl/rrnh_divsqrt.sv
// Shared restoring divider and digit-by-digit square root, one bit per cycle.
// Depends on rrnh_pkg for widths and the command struct.
`default_nettype none
module rrnh_divsqrt (
  input  wire                        clk,
  input  wire                        rst,
  input  wire rrnh_pkg::div_cmd_t    cmd,
  input  wire [rrnh_pkg::ACC_W-1:0]  rem_init,
  input  wire [63:0]                 src_init,
  input  wire [rrnh_pkg::ACC_W-1:0]  divisor,
  output logic                       busy,
  output logic [31:0]                quot
);

  logic [rrnh_pkg::ACC_W-1:0] rem;
  logic [rrnh_pkg::ACC_W-1:0] dsr;
  logic [63:0]                src;
  logic [5:0]                 cnt;
  logic                       sqrt_mode;
  logic [rrnh_pkg::ACC_W-1:0] trial;
  logic [rrnh_pkg::ACC_W-1:0] sub;
  logic [rrnh_pkg::ACC_W:0]   diff;
  logic                       ge;

  always_comb begin
    if (sqrt_mode) begin
      trial = {rem[rrnh_pkg::ACC_W-3:0], src[63:62]};
      sub   = {{(rrnh_pkg::ACC_W-34){1'b0}}, quot, 2'b01};
    end else begin
      trial = {rem[rrnh_pkg::ACC_W-2:0], src[63]};
      sub   = dsr;
    end
    diff = {1'b0, trial} - {1'b0, sub};
    ge   = ~diff[rrnh_pkg::ACC_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= cmd.steps;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem       <= rem_init;
      src       <= src_init;
      dsr       <= divisor;
      sqrt_mode <= cmd.sqrt_mode;
      quot      <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[rrnh_pkg::ACC_W-1:0] : trial;
      quot <= {quot[30:0], ge};
      src  <= sqrt_mode ? {src[61:0], 2'b00} : {src[62:0], 1'b0};
    end
  end

endmodule
`default_nettype wire
